// ----- hw/rtl/tcw_pkg.sv -----
// tcw_pkg: geometry, field widths, codes and cell helpers for the text
// console writer. No dependencies; imported by text_console_writer.
`default_nettype none

package tcw_pkg;

	// Screen geometry
	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int COPY_COUNT = CELL_COUNT - COLUMNS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);

	// Field widths
	localparam int COL_W     = 7;
	localparam int ROW_W     = 5;
	localparam int POS_W     = 11;
	localparam int CHAR_W    = 8;
	localparam int CLR_W     = 4;
	localparam int CELL_W    = 16;
	localparam int ACT_W     = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 8;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_STREAM = 2'd0;
	localparam logic [ACT_W-1:0] ACT_PUT    = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FG = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BG = 2'd1;

	// Character and colour constants
	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
	localparam logic [CLR_W-1:0]  FG_RESET     = 4'd7;
	localparam logic [CLR_W-1:0]  BG_RESET     = 4'd0;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SCROLL,
		ST_FLUSH
	} st_t;

	// Cell word: background, foreground, character
	function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0] ch,
			input logic [CLR_W-1:0] fg, input logic [CLR_W-1:0] bg);
		return {bg, fg, ch};
	endfunction

	// Linear cell address of a row and column
	function automatic logic [ADDR_W-1:0] lin_addr(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		return ADDR_W'(int'(row) * COLUMNS + int'(col));
	endfunction

	localparam logic [CELL_W-1:0] RESET_CELL = {BG_RESET, FG_RESET, SPACE_CODE};

endpackage : tcw_pkg

`default_nettype wire

// ----- hw/rtl/text_console_writer.sv -----
// text_console_writer: character cell console with its screen in one
// synchronous memory, cursor and colour registers, and a scroll sequencer.
// Depends on tcw_pkg.
`default_nettype none

// Command-style block: a word is taken when start is high and busy is low,
// and its result appears on the result ports for one cycle with done high,
// which the receiver must take as it comes. Streamed characters, puts,
// off-screen accesses and unused actions give their result the cycle after
// acceptance and busy stays low, so one of these can be taken every cycle.
// A read of an on-screen cell passes the registered memory read port and
// ST_READ before its result. A streamed character or newline that runs
// past the last row scrolls the screen: the cell memory is swept once,
// one cell per cycle through its single read and single write port, with
// busy high through ST_SCROLL and ST_FLUSH, and the result follows after
// that. After reset all cells are cleared to grey spaces in one pass with
// busy high; configuration writes are taken throughout.
module text_console_writer (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// command
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [tcw_pkg::ACT_W-1:0]      action,
	input  wire logic [tcw_pkg::CHAR_W-1:0]     char_code,
	input  wire logic [tcw_pkg::COL_W-1:0]      cell_col,
	input  wire logic [tcw_pkg::ROW_W-1:0]      cell_row,
	input  wire logic [tcw_pkg::CLR_W-1:0]      put_fg,
	input  wire logic [tcw_pkg::CLR_W-1:0]      put_bg,
	// result
	output logic                                done,
	output logic [tcw_pkg::POS_W-1:0]           cursor_pos,
	output logic [tcw_pkg::CELL_W-1:0]          cell_word,
	output logic                                scrolled,
	output logic                                bad_position,
	// configuration
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tcw_pkg::CFG_DAT_W-1:0]  cfg_data
);
	import tcw_pkg::*;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);

	st_t state_q, state_d;

	logic [CLR_W-1:0]  fg_q, bg_q;
	logic [COL_W-1:0]  cursor_col_q, col_d;
	logic [ROW_W-1:0]  cursor_row_q, row_d;
	logic [ADDR_W-1:0] idx_q, idx_d;

	// cell memory
	logic [CELL_W-1:0] mem [CELL_COUNT];
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [CELL_W-1:0] mem_wdata;
	logic [CELL_W-1:0] rd_data_q;

	// scroll write-back stage
	logic              wr_valid_s1;
	logic [ADDR_W-1:0] wr_addr_s1;
	logic              blank_s1;

	// result
	logic              emit, emit_scr, emit_bad;
	logic [CELL_W-1:0] emit_word;
	logic              done_q, scrolled_q, bad_q;
	logic [POS_W-1:0]  cursor_pos_q;
	logic [CELL_W-1:0] cell_word_q;

	// stream cursor advance
	logic              is_nl, wrap, need_scroll, on_screen;
	logic [COL_W:0]    col_inc;
	logic [COL_W-1:0]  stream_col;
	logic [ROW_W-1:0]  stream_row;
	logic [CELL_W-1:0] blank_cell;

	assign is_nl       = (char_code == NEWLINE_CODE);
	assign col_inc     = (COL_W+1)'(cursor_col_q) + (COL_W+1)'(1);
	assign wrap        = is_nl || (col_inc >= (COL_W+1)'(COLUMNS));
	assign need_scroll = wrap && (cursor_row_q == ROW_W'(ROWS - 1));
	assign stream_col  = wrap ? '0 : col_inc[COL_W-1:0];
	assign stream_row  = (wrap && !need_scroll) ? cursor_row_q + ROW_W'(1) : cursor_row_q;
	assign on_screen   = ((COL_W+1)'(cell_col) < (COL_W+1)'(COLUMNS))
	                  && ((ROW_W+1)'(cell_row) < (ROW_W+1)'(ROWS));
	assign blank_cell  = make_cell(SPACE_CODE, fg_q, bg_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (idx_q == LAST_ADDR) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					if (action == ACT_STREAM && need_scroll) state_d = ST_SCROLL;
					else if (action == ACT_READ && on_screen) state_d = ST_READ;
				end
			end
			ST_READ:   state_d = ST_IDLE;
			ST_SCROLL: begin
				if (idx_q == LAST_ADDR) state_d = ST_FLUSH;
			end
			ST_FLUSH:  state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// memory control, cursor update and result selection
	always_comb begin
		busy      = (state_q != ST_IDLE);
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = RESET_CELL;
		mem_re    = 1'b0;
		mem_raddr = ADDR_W'(int'(idx_q) + COLUMNS);
		emit      = 1'b0;
		emit_scr  = 1'b0;
		emit_bad  = 1'b0;
		emit_word = '0;
		col_d     = cursor_col_q;
		row_d     = cursor_row_q;
		idx_d     = idx_q;

		// scroll write-back of the previous cycle's read
		if (wr_valid_s1) begin
			mem_we    = 1'b1;
			mem_waddr = wr_addr_s1;
			mem_wdata = blank_s1 ? blank_cell : rd_data_q;
		end

		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = RESET_CELL;
				idx_d     = (idx_q == LAST_ADDR) ? '0 : idx_q + ADDR_W'(1);
			end
			ST_IDLE: begin
				if (start) begin
					unique case (action)
						ACT_STREAM: begin
							if (!is_nl) begin
								mem_we    = 1'b1;
								mem_waddr = lin_addr(cursor_row_q, cursor_col_q);
								mem_wdata = make_cell(char_code, fg_q, bg_q);
							end
							col_d = stream_col;
							row_d = stream_row;
							if (need_scroll) idx_d = '0;
							else emit = 1'b1;
						end
						ACT_PUT: begin
							if (on_screen) begin
								mem_we    = 1'b1;
								mem_waddr = lin_addr(cell_row, cell_col);
								mem_wdata = make_cell(char_code, put_fg, put_bg);
							end
							emit     = 1'b1;
							emit_bad = !on_screen;
						end
						ACT_READ: begin
							if (on_screen) begin
								mem_re    = 1'b1;
								mem_raddr = lin_addr(cell_row, cell_col);
							end else begin
								emit     = 1'b1;
								emit_bad = 1'b1;
							end
						end
						default: emit = 1'b1;
					endcase
				end
			end
			ST_READ: begin
				emit      = 1'b1;
				emit_word = rd_data_q;
			end
			ST_SCROLL: begin
				mem_re = (idx_q < ADDR_W'(COPY_COUNT));
				idx_d  = (idx_q == LAST_ADDR) ? '0 : idx_q + ADDR_W'(1);
			end
			ST_FLUSH: begin
				emit     = 1'b1;
				emit_scr = 1'b1;
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			idx_q        <= '0;
			cursor_col_q <= '0;
			cursor_row_q <= '0;
			wr_valid_s1  <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			state_q      <= state_d;
			idx_q        <= idx_d;
			cursor_col_q <= col_d;
			cursor_row_q <= row_d;
			wr_valid_s1  <= (state_q == ST_SCROLL);
			done_q       <= emit;
		end
	end

	// configuration registers, low nibble kept, unknown index ignored
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= FG_RESET;
			bg_q <= BG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FG:  fg_q <= cfg_data[CLR_W-1:0];
				REG_BG:  bg_q <= cfg_data[CLR_W-1:0];
				default: ;
			endcase
		end
	end

	// scroll stage: address and blank flag of the cell written next cycle
	always_ff @(posedge clk) begin
		wr_addr_s1 <= idx_q;
		blank_s1   <= (idx_q >= ADDR_W'(COPY_COUNT));
	end

	// result word
	always_ff @(posedge clk) begin
		if (emit) begin
			cursor_pos_q <= POS_W'(lin_addr(row_d, col_d));
			cell_word_q  <= emit_word;
			scrolled_q   <= emit_scr;
			bad_q        <= emit_bad;
		end
	end

	// cell memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rd_data_q <= mem[mem_raddr];
	end

	assign done         = done_q;
	assign cursor_pos   = cursor_pos_q;
	assign cell_word    = cell_word_q;
	assign scrolled     = scrolled_q;
	assign bad_position = bad_q;

`ifndef ASSERT_OFF
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cursor_col_q < COL_W'(COLUMNS)) && (cursor_row_q < ROW_W'(ROWS)))
		else $error("cursor left the screen");

	a_scroll_pos: assert property (@(posedge clk) disable iff (!arst_n)
		done && scrolled |-> cursor_pos == POS_W'((ROWS - 1) * COLUMNS))
		else $error("scroll result with cursor off the bottom row start");

	a_flush_only: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid_s1 |-> (state_q == ST_SCROLL || state_q == ST_FLUSH))
		else $error("scroll write-back outside scroll sequence");
`endif

endmodule : text_console_writer

`default_nettype wire
